/* rtl/core/yuvc_pkg.sv */
package yuvc_pkg;

    localparam int NUM_CLASSES  = 16;
    localparam int CHROMA_DEPTH = 65536;
    localparam int CHROMA_AW    = $clog2(CHROMA_DEPTH);
    localparam int RANGE_DEPTH  = 16;
    localparam int RANGE_AW     = $clog2(RANGE_DEPTH);
    localparam int CLASS_W      = 8;
    localparam int LUMA_W       = 8;

    localparam logic [CLASS_W-1:0] NO_CLASS = 8'd255;

    // request layout on s_axis_tdata, lowest bit first
    localparam int Y_FIRST_LSB   = 0;
    localparam int CHROMA_U_LSB  = 8;
    localparam int Y_SECOND_LSB  = 16;
    localparam int CHROMA_V_LSB  = 24;
    localparam int TBL_ADDR_LSB  = 32;
    localparam int TBL_CLASS_LSB = 48;
    localparam int RNG_CLASS_LSB = 56;
    localparam int RNG_MIN_LSB   = 60;
    localparam int RNG_MAX_LSB   = 68;
    localparam int IN_DATA_W     = 80;
    localparam int OUT_DATA_W    = 16;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_TABLE_WR = 2'd1,
        OP_RANGE_WR = 2'd2
    } op_t;

    // per-pair context shared by both luma lanes
    typedef struct packed {
        logic               hit;
        logic [CLASS_W-1:0] chroma_class;
        logic [LUMA_W-1:0]  luma_min;
        logic [LUMA_W-1:0]  luma_max;
    } lane_ctx_t;

endpackage

/* rtl/core/yuvc_chroma_ram.sv */
module yuvc_chroma_ram
(
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [yuvc_pkg::CHROMA_AW-1:0]      wr_addr,
    input  logic [yuvc_pkg::CLASS_W-1:0]        wr_data,
    input  logic                                rd_en,
    input  logic [yuvc_pkg::CHROMA_AW-1:0]      rd_addr,
    output logic [yuvc_pkg::CLASS_W-1:0]        rd_data
);

    logic [yuvc_pkg::CLASS_W-1:0] mem [yuvc_pkg::CHROMA_DEPTH];
    logic [yuvc_pkg::CLASS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/yuvc_lane.sv */
module yuvc_lane
(
    input  yuvc_pkg::lane_ctx_t                 ctx,
    input  logic [yuvc_pkg::LUMA_W-1:0]         luma,
    output logic [yuvc_pkg::CLASS_W-1:0]        code
);

    logic in_window;

    // inclusive window, an empty range (min above max) never matches
    assign in_window = (luma >= ctx.luma_min) && (luma <= ctx.luma_max);
    assign code      = (ctx.hit && in_window) ? ctx.chroma_class : yuvc_pkg::NO_CLASS;

endmodule

/* rtl/core/yuv_lut_color_classifier.sv */
// yuv_lut_color_classifier
// Color classification of YUYV pixel pairs through a 64K chroma table and
// 16 per-class luma windows.
// s_axis: one request per beat. tuser carries the operation (classify,
// chroma table write, luma range write); tdata carries the pixel pair and
// the write fields. Writes give no result.
// m_axis: one beat per classify request with the two class codes, 255
// meaning unclassified.
// Path: the chroma table read registers when a classify request is
// accepted, and the luma lanes load the output register from it once the
// output can advance.
// Throughput: one request per cycle while m_axis does not stall, set by the
// single read port of the chroma table, read once per pixel pair.
// Reset clears the loaded flag and empties the pipeline; table contents
// are not cleared and must be written before they are read.
// When m_axis_tready is low the output register holds its beat and one
// more classify result waits in the lane stage; s_axis_tready then drops
// until the output moves.
module yuv_lut_color_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // y_first, chroma_u, y_second, chroma_v, table_address, table_class,
    // range_class, range_min, range_max, zero pad
    input  logic [yuvc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation
    input  logic [1:0]                          s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // class_first, class_second
    output logic [yuvc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    yuvc_pkg::op_t                              in_op;
    logic                                       accept;
    logic                                       s1_adv;

    logic [yuvc_pkg::LUMA_W-1:0]                y_first;
    logic [yuvc_pkg::LUMA_W-1:0]                y_second;
    logic [7:0]                                 chroma_u;
    logic [7:0]                                 chroma_v;
    logic [yuvc_pkg::CHROMA_AW-1:0]             table_address;
    logic [yuvc_pkg::CLASS_W-1:0]               table_class;
    logic [yuvc_pkg::RANGE_AW-1:0]              range_class;
    logic [yuvc_pkg::LUMA_W-1:0]                range_min;
    logic [yuvc_pkg::LUMA_W-1:0]                range_max;

    logic                                       table_loaded_reg;
    logic                                       table_loaded_next;

    logic                                       s1_valid_reg;
    logic                                       s1_valid_next;
    logic                                       s1_loaded_reg;
    logic [yuvc_pkg::LUMA_W-1:0]                s1_y_first_reg;
    logic [yuvc_pkg::LUMA_W-1:0]                s1_y_second_reg;

    logic [yuvc_pkg::LUMA_W-1:0]                luma_min_reg [yuvc_pkg::RANGE_DEPTH];
    logic [yuvc_pkg::LUMA_W-1:0]                luma_max_reg [yuvc_pkg::RANGE_DEPTH];

    logic [yuvc_pkg::CLASS_W-1:0]               chroma_class;
    logic [yuvc_pkg::RANGE_AW-1:0]              range_idx;
    logic                                       class_valid;
    yuvc_pkg::lane_ctx_t                        ctx;
    logic [yuvc_pkg::CLASS_W-1:0]               code_first;
    logic [yuvc_pkg::CLASS_W-1:0]               code_second;

    logic                                       m_valid_reg;
    logic                                       m_valid_next;
    logic [yuvc_pkg::OUT_DATA_W-1:0]            m_data_reg;
    logic [yuvc_pkg::OUT_DATA_W-1:0]            m_data_next;

    // request fields
    assign in_op         = yuvc_pkg::op_t'(s_axis_tuser);
    assign y_first       = s_axis_tdata[yuvc_pkg::Y_FIRST_LSB +: yuvc_pkg::LUMA_W];
    assign chroma_u      = s_axis_tdata[yuvc_pkg::CHROMA_U_LSB +: 8];
    assign y_second      = s_axis_tdata[yuvc_pkg::Y_SECOND_LSB +: yuvc_pkg::LUMA_W];
    assign chroma_v      = s_axis_tdata[yuvc_pkg::CHROMA_V_LSB +: 8];
    assign table_address = s_axis_tdata[yuvc_pkg::TBL_ADDR_LSB +: yuvc_pkg::CHROMA_AW];
    assign table_class   = s_axis_tdata[yuvc_pkg::TBL_CLASS_LSB +: yuvc_pkg::CLASS_W];
    assign range_class   = s_axis_tdata[yuvc_pkg::RNG_CLASS_LSB +: yuvc_pkg::RANGE_AW];
    assign range_min     = s_axis_tdata[yuvc_pkg::RNG_MIN_LSB +: yuvc_pkg::LUMA_W];
    assign range_max     = s_axis_tdata[yuvc_pkg::RNG_MAX_LSB +: yuvc_pkg::LUMA_W];

    // the lane stage always drains when a request is taken, so range writes
    // never overtake a classify still waiting for its windows
    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    yuvc_chroma_ram u_chroma_ram
    (
        .clk     (clk),
        .wr_en   (accept && (in_op == yuvc_pkg::OP_TABLE_WR)),
        .wr_addr (table_address),
        .wr_data (table_class),
        .rd_en   (accept && (in_op == yuvc_pkg::OP_CLASSIFY)),
        .rd_addr ({chroma_u, chroma_v}),
        .rd_data (chroma_class)
    );

    always_comb
    begin
        table_loaded_next = table_loaded_reg;
        s1_valid_next     = s1_valid_reg;
        if (accept)
        begin
            case (in_op)
                yuvc_pkg::OP_CLASSIFY:
                begin
                    s1_valid_next = 1'b1;
                end
                yuvc_pkg::OP_TABLE_WR:
                begin
                    table_loaded_next = 1'b1;
                    s1_valid_next     = 1'b0;
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_loaded_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            table_loaded_reg <= table_loaded_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_op == yuvc_pkg::OP_CLASSIFY))
        begin
            s1_loaded_reg   <= table_loaded_reg;
            s1_y_first_reg  <= y_first;
            s1_y_second_reg <= y_second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (in_op == yuvc_pkg::OP_RANGE_WR))
        begin
            luma_min_reg[range_class] <= range_min;
            luma_max_reg[range_class] <= range_max;
        end
    end

    // classes at or past the class count or the range storage are none
    assign class_valid = (chroma_class < yuvc_pkg::CLASS_W'(yuvc_pkg::NUM_CLASSES))
                      && (chroma_class < yuvc_pkg::CLASS_W'(yuvc_pkg::RANGE_DEPTH));
    assign range_idx   = chroma_class[yuvc_pkg::RANGE_AW-1:0];

    assign ctx.hit          = s1_loaded_reg && class_valid;
    assign ctx.chroma_class = chroma_class;
    assign ctx.luma_min     = luma_min_reg[range_idx];
    assign ctx.luma_max     = luma_max_reg[range_idx];

    yuvc_lane u_lane_first
    (
        .ctx  (ctx),
        .luma (s1_y_first_reg),
        .code (code_first)
    );

    yuvc_lane u_lane_second
    (
        .ctx  (ctx),
        .luma (s1_y_second_reg),
        .code (code_second)
    );

    // merge both lanes into the output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s1_adv)
        begin
            m_valid_next = s1_valid_reg;
            m_data_next  = {code_second, code_first};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while lane stage is stalled");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op != yuvc_pkg::OP_CLASSIFY)) |=> !s1_valid_reg)
        else $error("write request entered the lane stage");

    a_result_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg))
        else $error("result appeared without a lane stage entry");

    a_unloaded_is_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !table_loaded_reg)
            |-> (m_axis_tdata == {yuvc_pkg::NO_CLASS, yuvc_pkg::NO_CLASS}))
        else $error("class given before any chroma table write");

endmodule
